/* rtl/ldbdm_pkg.sv */
// ----------------------------------------------------------------------------
// ldbdm_pkg
// Types and constants shared by the path database decoder and its testbench.
// ----------------------------------------------------------------------------
package ldbdm_pkg;

    localparam int BIGRAM_COUNT      = 128;
    localparam int TABLE_BYTES       = 2 * BIGRAM_COUNT;
    localparam logic [7:0] SWITCH_CODE = 8'd30;
    localparam logic [7:0] PARITY      = 8'd128;
    localparam logic [4:0] COUNT_OFFSET_RESET = 5'd14;

    typedef enum logic [1:0] {
        ACT_DB_BYTE  = 2'd0,
        ACT_DB_END   = 2'd1,
        ACT_PAT_BYTE = 2'd2,
        ACT_RESTART  = 2'd3
    } action_t;

    localparam logic [1:0] REG_COUNT_OFFSET = 2'd0;
    localparam logic [1:0] REG_WORD_BE      = 2'd1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_out;
        logic [9:0]  char_position;
        logic [10:0] path_length;
        logic        matched;
        logic        error;
        logic        last;
    } out_item_t;

endpackage

/* rtl/locate_database_decode_match.sv */
// A character result is registered from S_CHAR after its input item has passed S_PROC, once
// the output slot is free; the second character of a bigram follows once the first is taken.
// Items are taken only in S_IDLE, so an item and all its results finish before the next.
// A record close adds a backward walk: S_SCAN_RD and S_SCAN_CMP per compare, S_SCAN_RD per
// start position too near 0, S_SCAN_RD for the end check unless a match ends it, and S_REPORT.
// Reset is asynchronous, active low, clears all control state; RAM contents undefined.
// ----------------------------------------------------------------------------
// locate_database_decode_match
// Front-compressed bigram path database decoder with backward subpattern match.
// ----------------------------------------------------------------------------
module locate_database_decode_match
    import ldbdm_pkg::*;
#(
    parameter int PATH_DEPTH    = 1024,
    parameter int PATTERN_DEPTH = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int AW  = $clog2(PATH_DEPTH);
    localparam int LW  = $clog2(PATH_DEPTH + 1);
    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int PLW = $clog2(PATTERN_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PROC, S_CHAR, S_SCAN_RD, S_SCAN_CMP, S_REPORT
    } state_t;

    state_t         state_reg;
    logic [4:0]     count_offset_reg;
    logic           word_be_reg;
    logic [1:0]     act_reg;
    logic [7:0]     byte_reg;
    logic [PLW-1:0] plen_reg;
    logic [LW-1:0]  prefix_reg;
    logic [LW-1:0]  wp_reg;
    logic           prev_found_reg;
    logic [8:0]     tli_reg;
    logic [2:0]     esc_reg;
    logic [31:0]    word_reg;
    logic           open_reg;
    logic           rec_err_reg;
    logic [7:0]     ch_a_reg;
    logic [7:0]     ch_b_reg;
    logic           two_reg;
    logic           pending_reg;
    logic [LW-1:0]  s1_reg;
    logic [LW-1:0]  cut_reg;
    logic [PAW-1:0] k_reg;
    logic           found_reg;
    logic           out_valid_reg;
    out_item_t      out_reg;

    logic [7:0]     bf_rdata, bs_rdata, path_rdata, pat_rdata;
    logic           bf_we, bs_we, path_we, pat_we;
    logic [AW-1:0]  path_raddr;
    logic [PAW-1:0] pat_raddr;
    logic [PAW-1:0] lastp;
    logic           slot_free;
    logic [1:0]     esc_k;
    logic [31:0]    word_next;
    logic signed [34:0] delta;
    logic signed [34:0] open_sum;
    logic [LW-1:0]  open_count;
    logic           open_err;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign slot_free    = !out_valid_reg || result_ready;
    assign lastp        = PAW'(plen_reg - PLW'(1));

    // escape word assembly
    assign esc_k     = 2'(esc_reg - 3'd1);
    assign word_next = word_be_reg ? {word_reg[23:0], byte_reg}
                                   : (word_reg | (32'(byte_reg) << {esc_k, 3'b000}));

    // new prefix count, clamped to the buffer
    always_comb
    begin
        if (state_reg == S_PROC && esc_reg != 3'd0)
            delta = 35'(signed'(word_next));
        else
            delta = 35'(byte_reg);
        open_sum = 35'(prefix_reg) + delta - 35'(count_offset_reg);
        if (open_sum < 0)
        begin
            open_count = '0;
            open_err   = 1'b1;
        end
        else if (open_sum > 35'(PATH_DEPTH))
        begin
            open_count = LW'(PATH_DEPTH);
            open_err   = 1'b1;
        end
        else
        begin
            open_count = LW'(open_sum);
            open_err   = 1'b0;
        end
    end

    assign bf_we   = (state_reg == S_PROC) && !tli_reg[8] && act_reg == ACT_DB_BYTE
                     && !tli_reg[0];
    assign bs_we   = (state_reg == S_PROC) && !tli_reg[8] && act_reg == ACT_DB_BYTE
                     && tli_reg[0];
    assign pat_we  = (state_reg == S_PROC) && act_reg == ACT_PAT_BYTE
                     && plen_reg < PLW'(PATTERN_DEPTH);
    assign path_we = (state_reg == S_CHAR) && wp_reg < LW'(PATH_DEPTH) && slot_free;

    assign path_raddr = AW'(int'(s1_reg) - 1 - int'(k_reg));
    assign pat_raddr  = (state_reg == S_SCAN_RD) ? PAW'(lastp - k_reg) : '0;

    ldbdm_ram #(.WIDTH(8), .DEPTH(BIGRAM_COUNT)) u_bigram_first (
        .clk(clk), .we(bf_we), .waddr(tli_reg[7:1]), .wdata(byte_reg),
        .raddr(item.data_byte[6:0]), .rdata(bf_rdata)
    );

    ldbdm_ram #(.WIDTH(8), .DEPTH(BIGRAM_COUNT)) u_bigram_second (
        .clk(clk), .we(bs_we), .waddr(tli_reg[7:1]), .wdata(byte_reg),
        .raddr(item.data_byte[6:0]), .rdata(bs_rdata)
    );

    ldbdm_ram #(.WIDTH(8), .DEPTH(PATH_DEPTH)) u_path (
        .clk(clk), .we(path_we), .waddr(AW'(wp_reg)), .wdata(ch_a_reg),
        .raddr(path_raddr), .rdata(path_rdata)
    );

    ldbdm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pattern (
        .clk(clk), .we(pat_we), .waddr(PAW'(plen_reg)), .wdata(byte_reg),
        .raddr(pat_raddr), .rdata(pat_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_offset_reg <= COUNT_OFFSET_RESET;
            word_be_reg      <= 1'b0;
            plen_reg         <= '0;
            prefix_reg       <= '0;
            wp_reg           <= '0;
            prev_found_reg   <= 1'b0;
            tli_reg          <= '0;
            esc_reg          <= '0;
            word_reg         <= '0;
            open_reg         <= 1'b0;
            rec_err_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_COUNT_OFFSET)
                    count_offset_reg <= cfg_data;
                else if (cfg_index == REG_WORD_BE)
                    word_be_reg <= cfg_data[0];
            end
            if (out_valid_reg && result_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        act_reg   <= item.action;
                        byte_reg  <= item.data_byte;
                        state_reg <= S_PROC;
                    end
                end
                S_PROC:
                begin
                    state_reg <= S_IDLE;
                    if (act_reg == ACT_RESTART)
                    begin
                        plen_reg       <= '0;
                        prefix_reg     <= '0;
                        wp_reg         <= '0;
                        prev_found_reg <= 1'b0;
                        tli_reg        <= '0;
                        esc_reg        <= '0;
                        word_reg       <= '0;
                        open_reg       <= 1'b0;
                        rec_err_reg    <= 1'b0;
                    end
                    else if (act_reg == ACT_PAT_BYTE)
                    begin
                        if (pat_we)
                            plen_reg <= plen_reg + PLW'(1);
                    end
                    else if (!tli_reg[8])
                    begin
                        if (act_reg == ACT_DB_BYTE)
                            tli_reg <= tli_reg + 9'd1;
                    end
                    else if (act_reg == ACT_DB_END)
                    begin
                        esc_reg <= '0;
                        if (open_reg)
                        begin
                            pending_reg <= 1'b0;
                            s1_reg      <= wp_reg;
                            cut_reg     <= prev_found_reg ? '0 : prefix_reg;
                            k_reg       <= '0;
                            found_reg   <= 1'b0;
                            state_reg   <= (plen_reg == '0) ? S_REPORT : S_SCAN_RD;
                        end
                    end
                    else if (esc_reg != 3'd0)
                    begin
                        word_reg <= word_next;
                        if (esc_reg == 3'd4)
                        begin
                            esc_reg     <= '0;
                            prefix_reg  <= open_count;
                            wp_reg      <= open_count;
                            rec_err_reg <= open_err;
                            open_reg    <= 1'b1;
                        end
                        else
                            esc_reg <= esc_reg + 3'd1;
                    end
                    else if (!open_reg)
                    begin
                        if (byte_reg == SWITCH_CODE)
                        begin
                            esc_reg  <= 3'd1;
                            word_reg <= '0;
                        end
                        else
                        begin
                            prefix_reg  <= open_count;
                            wp_reg      <= open_count;
                            rec_err_reg <= open_err;
                            open_reg    <= 1'b1;
                        end
                    end
                    else if (byte_reg > SWITCH_CODE)
                    begin
                        if (byte_reg < PARITY)
                        begin
                            ch_a_reg <= byte_reg;
                            two_reg  <= 1'b0;
                        end
                        else
                        begin
                            ch_a_reg <= bf_rdata;
                            ch_b_reg <= bs_rdata;
                            two_reg  <= 1'b1;
                        end
                        state_reg <= S_CHAR;
                    end
                    else
                    begin
                        // close, then take this byte as the next delta code
                        pending_reg <= 1'b1;
                        s1_reg      <= wp_reg;
                        cut_reg     <= prev_found_reg ? '0 : prefix_reg;
                        k_reg       <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= (plen_reg == '0) ? S_REPORT : S_SCAN_RD;
                    end
                end
                S_CHAR:
                begin
                    if (wp_reg >= LW'(PATH_DEPTH))
                    begin
                        rec_err_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.kind          <= 1'b0;
                        out_reg.char_out      <= ch_a_reg;
                        out_reg.char_position <= 10'(wp_reg);
                        out_reg.path_length   <= '0;
                        out_reg.matched       <= 1'b0;
                        out_reg.error         <= rec_err_reg;
                        out_reg.last          <= !two_reg
                                                 || (wp_reg + LW'(1)) >= LW'(PATH_DEPTH);
                        wp_reg   <= wp_reg + LW'(1);
                        ch_a_reg <= ch_b_reg;
                        two_reg  <= 1'b0;
                        if (!two_reg)
                            state_reg <= S_IDLE;
                    end
                end
                S_SCAN_RD:
                begin
                    if (s1_reg <= cut_reg)
                        state_reg <= S_REPORT;
                    else if (int'(s1_reg) <= int'(k_reg))
                    begin
                        // pattern would reach before the path start
                        s1_reg <= s1_reg - LW'(1);
                        k_reg  <= '0;
                    end
                    else
                        state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    state_reg <= S_SCAN_RD;
                    if (path_rdata == pat_rdata)
                    begin
                        if (k_reg == lastp)
                        begin
                            found_reg <= 1'b1;
                            state_reg <= S_REPORT;
                        end
                        else
                            k_reg <= k_reg + PAW'(1);
                    end
                    else
                    begin
                        s1_reg <= s1_reg - LW'(1);
                        k_reg  <= '0;
                    end
                end
                S_REPORT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.kind          <= 1'b1;
                        out_reg.char_out      <= '0;
                        out_reg.char_position <= '0;
                        out_reg.path_length   <= 11'(wp_reg);
                        out_reg.matched       <= found_reg;
                        out_reg.error         <= rec_err_reg;
                        out_reg.last          <= 1'b1;
                        prev_found_reg        <= found_reg;
                        open_reg              <= 1'b0;
                        state_reg             <= S_IDLE;
                        if (pending_reg)
                        begin
                            if (byte_reg == SWITCH_CODE)
                            begin
                                esc_reg  <= 3'd1;
                                word_reg <= '0;
                            end
                            else
                            begin
                                prefix_reg  <= open_count;
                                wp_reg      <= open_count;
                                rec_err_reg <= open_err;
                                open_reg    <= 1'b1;
                            end
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_path_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        path_we |-> wp_reg < LW'(PATH_DEPTH))
        else $error("path write beyond buffer");

    a_esc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg <= 3'd4)
        else $error("escape byte count out of range");

    a_no_record_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        !tli_reg[8] |-> !open_reg && esc_reg == 3'd0)
        else $error("record open during table load");

    a_scan_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CMP |-> k_reg <= lastp && plen_reg != '0)
        else $error("scan index past pattern");
`endif

endmodule

/* rtl/ldbdm_ram.sv */
// ----------------------------------------------------------------------------
// ldbdm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ldbdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* test/locate_database_decode_match_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locate_database_decode_match_test
// Feeds bigram tables, front-compressed records, escaped counts, pattern
// bytes and restarts to the decoder under random idling on both channels,
// predicts every character and record report, and checks them in order.
// ----------------------------------------------------------------------------
module locate_database_decode_match_test;
    import ldbdm_pkg::*;

    localparam int PATH_MAX  = 1024;
    localparam int PAT_MAX   = 128;
    localparam int CYCLE_CAP = 1000000;

    class decode_scoreboard;
        logic [7:0]  pair_first[BIGRAM_COUNT];
        logic [7:0]  pair_second[BIGRAM_COUNT];
        logic [7:0]  path_mem[PATH_MAX];
        logic [7:0]  pat_mem[PAT_MAX];
        int          pat_len, prefix, wpos, tbl_idx, esc_seen;
        logic [31:0] esc_word;
        bit          prev_found, rec_open, rec_err;
        int          offset;
        bit          big_end;
        int          extent;      // positions 0..extent-1 hold written path bytes
        out_item_t   pending[$];
        int          errors, items, chars, closes, hits;

        function new();
            offset  = int'(COUNT_OFFSET_RESET);
            big_end = 0;
            errors  = 0;
            items   = 0;
            chars   = 0;
            closes  = 0;
            hits    = 0;
            clear();
        endfunction

        function void clear();
            pat_len    = 0;
            prefix     = 0;
            wpos       = 0;
            tbl_idx    = 0;
            esc_seen   = 0;
            esc_word   = '0;
            prev_found = 0;
            rec_open   = 0;
            rec_err    = 0;
            extent     = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void open_rec(longint delta);
            longint n;
            n = prefix + delta;
            rec_err = 0;
            if (n < 0) begin
                n = 0;
                rec_err = 1;
            end
            else if (n > PATH_MAX) begin
                n = PATH_MAX;
                rec_err = 1;
            end
            prefix   = int'(n);
            wpos     = int'(n);
            rec_open = 1;
        endfunction

        function void count_code(logic [7:0] b);
            if (b == SWITCH_CODE) begin
                esc_seen = 1;
                esc_word = '0;
                rec_open = 0;
            end
            else
                open_rec(longint'(b) - offset);
        endfunction

        function void escape_byte(logic [7:0] b);
            int k;
            int sw;
            k = (esc_seen - 1) & 3;
            if (big_end)
                esc_word = {esc_word[23:0], b};
            else
                esc_word = esc_word | (32'(b) << (8 * k));
            esc_seen++;
            if (esc_seen < 5)
                return;
            esc_seen = 0;
            sw = esc_word;
            open_rec(longint'(sw) - offset);
        endfunction

        function void put_char(logic [7:0] ch, ref out_item_t batch[$]);
            out_item_t r;
            if (wpos >= PATH_MAX) begin
                rec_err = 1;
                return;
            end
            path_mem[wpos] = ch;
            if (wpos == extent)
                extent++;
            r = '0;
            r.char_out      = ch;
            r.char_position = wpos[9:0];
            r.error         = rec_err;
            batch.push_back(r);
            wpos++;
        endfunction

        function void close_path(ref out_item_t batch[$]);
            out_item_t r;
            int cut, s, k, lastp;
            bit found, ok;
            cut   = prev_found ? 0 : prefix;
            found = 0;
            if (pat_len > 0) begin
                lastp = pat_len - 1;
                for (s = wpos - 1; s >= cut && !found; s--) begin
                    if (path_mem[s] != pat_mem[lastp])
                        continue;
                    ok = 1;
                    for (k = 1; k <= lastp; k++) begin
                        // a compare reaching before the path start is a miss
                        if (s - k < 0 || path_mem[s - k] != pat_mem[lastp - k]) begin
                            ok = 0;
                            break;
                        end
                    end
                    found = ok;
                end
            end
            prev_found = found;
            rec_open   = 0;
            r = '0;
            r.kind        = 1'b1;
            r.path_length = wpos[10:0];
            r.matched     = found;
            r.error       = rec_err;
            batch.push_back(r);
        endfunction

        function void note_input(in_item_t it);
            out_item_t batch[$];
            logic [7:0] b;
            int i;
            b = it.data_byte;
            items++;
            case (action_t'(it.action))
                ACT_RESTART: clear();
                ACT_PAT_BYTE: begin
                    if (pat_len < PAT_MAX)
                        pat_mem[pat_len++] = b;
                end
                default: begin
                    if (tbl_idx < TABLE_BYTES) begin
                        if (it.action == ACT_DB_BYTE) begin
                            i = tbl_idx >> 1;
                            if (tbl_idx & 1)
                                pair_second[i] = b;
                            else
                                pair_first[i] = b;
                            tbl_idx++;
                        end
                    end
                    else if (it.action == ACT_DB_END) begin
                        esc_seen = 0;
                        if (rec_open)
                            close_path(batch);
                    end
                    else if (esc_seen != 0)
                        escape_byte(b);
                    else if (!rec_open)
                        count_code(b);
                    else if (b > SWITCH_CODE) begin
                        if (b < PARITY)
                            put_char(b, batch);
                        else begin
                            put_char(pair_first[b[6:0]], batch);
                            put_char(pair_second[b[6:0]], batch);
                        end
                    end
                    else begin
                        close_path(batch);
                        count_code(b);
                    end
                end
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                pending.push_back(batch[j]);
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.char_out != want.char_out)
                report($sformatf("char_out %h, expected %h", got.char_out, want.char_out));
            if (got.char_position != want.char_position)
                report($sformatf("char_position %0d, expected %0d",
                                 got.char_position, want.char_position));
            if (got.path_length != want.path_length)
                report($sformatf("path_length %0d, expected %0d",
                                 got.path_length, want.path_length));
            if (got.matched != want.matched)
                report($sformatf("matched %0d, expected %0d", got.matched, want.matched));
            if (got.error != want.error)
                report($sformatf("error %0d, expected %0d", got.error, want.error));
            if (got.last != want.last)
                report($sformatf("last %0d, expected %0d", got.last, want.last));
            if (want.kind) begin
                closes++;
                if (want.matched)
                    hits++;
            end
            else
                chars++;
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    in_item_t   item;
    logic       result_valid;
    logic       result_ready;
    out_item_t  result;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    decode_scoreboard sb;
    int send_idle, rx_idle;
    int hold_ticket, hold_served, hold_left;
    int random_items;

    locate_database_decode_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver: checks each transfer, idles at random, long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
        if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle);
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_CAP);
        $display("locate_database_decode_match_test: FAIL");
        $finish;
    end

    task send(logic [1:0] act, logic [7:0] data);
        in_item_t it;
        it.action    = act;
        it.data_byte = data;
        item       <= it;
        item_valid <= 1'b1;
        forever begin
            @(posedge clk);
            if (item_ready)
                break;
        end
        sb.note_input(it);
        if ($urandom_range(99) < send_idle) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task db(logic [7:0] data);
        send(ACT_DB_BYTE, data);
    endtask

    task drain();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task write_regs(logic [4:0] offset, logic big_end);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COUNT_OFFSET;
        cfg_data  <= offset;
        @(posedge clk);
        cfg_index <= REG_WORD_BE;
        cfg_data  <= {4'd0, big_end};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.offset  = int'(offset);
        sb.big_end = big_end;
    endtask

    function logic [7:0] path_letter();
        case ($urandom_range(2))
            0: return "a";
            1: return "b";
            default: return "/";
        endcase
    endfunction

    // narrow tables use the path letters so that patterns can hit
    task load_tables(bit narrow);
        repeat (TABLE_BYTES) begin
            if (narrow && $urandom_range(9) != 0)
                db(path_letter());
            else
                db(8'($urandom_range(255)));
        end
    endtask

    task restart_with_pattern(int pat_bytes, bit narrow);
        send(ACT_RESTART, 8'($urandom_range(255)));
        repeat (pat_bytes)
            send(ACT_PAT_BYTE, narrow ? path_letter() : 8'($urandom_range(255)));
        load_tables(narrow);
    endtask

    task word_escape(logic [31:0] w);
        db(SWITCH_CODE);
        for (int i = 0; i < 4; i++)
            db(sb.big_end ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
    endtask

    // start a record whose prefix becomes target, by code byte or escaped word
    task open_path(int target);
        int code, lim;
        code = target - sb.prefix + sb.offset;
        lim  = sb.rec_open ? SWITCH_CODE - 1 : 255;
        if (code >= 0 && code <= lim && code != SWITCH_CODE && $urandom_range(3) != 0)
            db(8'(code));
        else
            word_escape(code);
    endtask

    task path_char();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            db(path_letter());
        else if (r < 75)
            db(8'($urandom_range(31, 127)));
        else
            db(8'($urandom_range(128, 255)));
    endtask

    task random_record();
        int lim, target;
        lim    = sb.extent < 48 ? sb.extent : 48;
        target = ($urandom_range(7) == 0) ? sb.extent : $urandom_range(lim);
        open_path(target);
        repeat ($urandom_range(8))
            path_char();
    endtask

    task random_traffic(int count);
        int stop_at, r;
        stop_at = sb.items + count;
        while (sb.items < stop_at) begin
            r = $urandom_range(99);
            if (r < 4)
                send(ACT_DB_END, 8'($urandom_range(255)));
            else if (r < 8) begin
                if (sb.pat_len < 4)
                    send(ACT_PAT_BYTE, path_letter());
            end
            else if (r < 10) begin
                // escape cut short by end of database
                db(SWITCH_CODE);
                repeat ($urandom_range(3))
                    db(8'($urandom_range(255)));
                send(ACT_DB_END, 8'($urandom_range(255)));
            end
            else if (r < 13)
                open_path(-int'($urandom_range(1, 3000)));
            else if (r < 15 && sb.extent == PATH_MAX) begin
                if ($urandom_range(1))
                    word_escape(32'h7fff_0000 + $urandom_range(65535));
                else
                    open_path(PATH_MAX + $urandom_range(1, 40));
            end
            else
                random_record();
        end
    endtask

    // with an empty pattern nothing below the prefix is read, so the record
    // may start near the end and run the buffer full and past it
    task fill_buffer();
        open_path(PATH_MAX - 6);
        while (sb.wpos < PATH_MAX)
            db(8'($urandom_range(128, 255)));
        repeat (3)
            db(8'($urandom_range(128, 255)));
        send(ACT_DB_END, 8'h00);
        // count above range, its character dropped
        open_path(PATH_MAX + 20);
        db("a");
        send(ACT_DB_END, 8'h00);
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        result_ready = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_ticket = 0;
        hold_served = 0;
        hold_left   = 0;
        send_idle   = 29;
        rx_idle     = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        write_regs(5'd0, 1'b0);
        send(ACT_DB_END, 8'hff);            // tables not loaded: nothing happens
        send(ACT_PAT_BYTE, 8'hff);
        send(ACT_PAT_BYTE, 8'h00);
        send(ACT_RESTART, 8'h00);
        send(ACT_PAT_BYTE, "a");
        send(ACT_PAT_BYTE, "b");
        load_tables(1'b1);
        db(8'd0);                           // prefix 0
        db(8'd31);
        db(8'd127);
        db("a");
        db("b");
        db(8'd128);
        db(8'd255);
        word_escape(32'd3);                 // close, prefix 3
        db("a");
        db("b");
        db(SWITCH_CODE);
        db(8'd1);
        send(ACT_DB_END, 8'h00);            // pending escape dropped
        db(8'd0);
        db("b");
        send(ACT_DB_END, 8'h00);
        word_escape(32'hffff_ff00);         // count below zero
        db("a");
        db(8'd29);
        send(ACT_DB_END, 8'h00);
        drain();

        // phase 1
        write_regs(5'd30, 1'b1);
        random_items = 40;
        random_traffic(random_items);
        drain();

        // phase 2: long receiver hold-off while the sender keeps offering
        send_idle = 50;
        rx_idle   = 29;
        write_regs(5'($urandom_range(1, 29)), 1'b0);
        hold_ticket <= hold_ticket + 1;
        random_traffic(60);
        drain();

        // phase 3: no idling, full buffer, count above range, full pattern
        send_idle = 0;
        rx_idle   = 0;
        write_regs(5'd14, 1'b1);
        restart_with_pattern(0, 1'b0);
        fill_buffer();
        repeat (PAT_MAX + 1)
            send(ACT_PAT_BYTE, path_letter());
        random_traffic(20);
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        random_traffic(20);
        send(ACT_DB_END, 8'h00);
        drain();

        $display("%0d items, %0d characters, %0d records closed, %0d matched",
                 sb.items, sb.chars, sb.closes, sb.hits);
        $display("%0d mismatches; offsets 0, 30, 14 and a random one, both word orders",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("locate_database_decode_match_test: PASS");
        else
            $display("locate_database_decode_match_test: FAIL");
        $finish;
    end

endmodule
